FILE: sv/slbm_pkg.sv
// Shared types and constants for the serial loaded bank mapper.
// Holds the mapper state record, the translated access record and code names.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slbm_pkg;

  // Access kinds on the bus side
  localparam logic [1:0] FUNC_CPU_RD = 2'd0;
  localparam logic [1:0] FUNC_CPU_WR = 2'd1;
  localparam logic [1:0] FUNC_PPU_RD = 2'd2;
  localparam logic [1:0] FUNC_PPU_WR = 2'd3;

  // Internal register picked by address bits 14:13
  localparam logic [1:0] REG_CONTROL = 2'd0;
  localparam logic [1:0] REG_CHR0    = 2'd1;
  localparam logic [1:0] REG_CHR1    = 2'd2;
  localparam logic [1:0] REG_PRG     = 2'd3;

  // PRG layouts
  localparam logic [1:0] PRG_32K_A    = 2'd0;
  localparam logic [1:0] PRG_32K_B    = 2'd1;
  localparam logic [1:0] PRG_FIX_FST  = 2'd2;
  localparam logic [1:0] PRG_FIX_LST  = 2'd3;

  localparam logic [4:0]  SHIFT_EMPTY    = 5'h10;
  localparam logic [4:0]  PRG_BANKS_RST  = 5'd16;
  localparam logic [15:0] RAM_BASE       = 16'h6000;
  localparam logic [15:0] REG_BASE       = 16'h8000;
  localparam logic [15:0] PPU_LIMIT      = 16'h2000;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_ROM  = 2'd2,
    TGT_CHR  = 2'd3
  } slbm_target_t;

  typedef struct packed {
    logic [4:0]  shift_load;
    logic [31:0] last_write_cycle;
    logic [1:0]  mirror_sel;
    logic [1:0]  prg_mode;
    logic        chr_mode;
    logic [3:0]  prg_bank;
    logic [4:0]  chr_bank_low;
    logic [4:0]  chr_bank_high;
    logic        prg_ram_off;
  } slbm_state_t;

  typedef struct packed {
    slbm_target_t target;
    logic [17:0]  mem_offset;
    logic         mem_write;
    logic [7:0]   mem_data;
  } slbm_result_t;

endpackage

`default_nettype wire

FILE: sv/slbm_loader.sv
// Serial load register and mapper control/bank registers.
// Depends on slbm_pkg for the state record and register codes.
`timescale 1ns / 1ps
`default_nettype none

module slbm_loader (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      step,
  input  wire  [1:0]               func,
  input  wire  [15:0]              address,
  input  wire  [7:0]               write_data,
  input  wire  [31:0]              cpu_cycle,
  output slbm_pkg::slbm_state_t    state,
  output logic [1:0]               mirror_next
);
  import slbm_pkg::*;

  slbm_state_t state_next;
  logic        reg_wr;
  logic        skip;
  logic [4:0]  shifted;

  assign reg_wr  = step && (func == FUNC_CPU_WR) && (address >= REG_BASE);
  assign skip    = (cpu_cycle == (state.last_write_cycle + 32'd1));
  assign shifted = {write_data[0], state.shift_load[4:1]};

  always_comb begin
    state_next = state;
    if (reg_wr && !skip) begin
      state_next.last_write_cycle = cpu_cycle;
      if (write_data[7]) begin
        state_next.shift_load = SHIFT_EMPTY;
        state_next.prg_mode   = PRG_FIX_LST;
      end else if (state.shift_load[0]) begin
        // fifth bit: commit and empty
        state_next.shift_load = SHIFT_EMPTY;
        unique case (address[14:13])
          REG_CONTROL: begin
            state_next.mirror_sel = shifted[1:0];
            state_next.prg_mode   = shifted[3:2];
            state_next.chr_mode   = shifted[4];
          end
          REG_CHR0: state_next.chr_bank_low  = shifted;
          REG_CHR1: state_next.chr_bank_high = shifted;
          REG_PRG: begin
            state_next.prg_bank    = shifted[3:0];
            state_next.prg_ram_off = shifted[4];
          end
          default: state_next.prg_bank = state.prg_bank;
        endcase
      end else begin
        state_next.shift_load = shifted;
      end
    end
  end

  assign mirror_next = state_next.mirror_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{shift_load: SHIFT_EMPTY, default: '0};
    end else begin
      state <= state_next;
    end
  end

  a_marker_kept: assert property (@(posedge clk) disable iff (rst)
    state.shift_load != 5'd0)
    else $error("shift register lost its marker bit");

  a_reset_bit: assert property (@(posedge clk) disable iff (rst)
    reg_wr && !skip && write_data[7] |=>
      state.prg_mode == PRG_FIX_LST && state.shift_load == SHIFT_EMPTY)
    else $error("reset bit did not empty the shift register");

  a_skip_holds: assert property (@(posedge clk) disable iff (rst)
    reg_wr && skip |=> $stable(state))
    else $error("back-to-back write changed mapper state");

endmodule

`default_nettype wire

FILE: sv/slbm_xlate.sv
// Address translation from a bus access to a cartridge memory access.
// Depends on slbm_pkg for the state and result records.
`timescale 1ns / 1ps
`default_nettype none

module slbm_xlate (
  input  wire  [1:0]               func,
  input  wire  [15:0]              address,
  input  wire  [7:0]               write_data,
  input  slbm_pkg::slbm_state_t    state,
  input  wire  [4:0]               prg_rom_banks,
  output slbm_pkg::slbm_result_t   result
);
  import slbm_pkg::*;

  logic       wr;
  logic       hi_half;
  logic [4:0] last_bank;
  logic [3:0] prg_sel;
  logic [4:0] chr_sel;
  logic [17:0] rom_off;
  logic [17:0] chr_off;

  assign wr        = func[0];
  assign hi_half   = address[15] & address[14];
  assign last_bank = prg_rom_banks - 5'd1;

  always_comb begin
    unique case (state.prg_mode)
      PRG_32K_A, PRG_32K_B: prg_sel = {state.prg_bank[3:1], hi_half};
      PRG_FIX_FST:          prg_sel = hi_half ? state.prg_bank : 4'd0;
      PRG_FIX_LST:          prg_sel = hi_half ? last_bank[3:0] : state.prg_bank;
      default:              prg_sel = state.prg_bank;
    endcase
  end

  always_comb begin
    if (!state.chr_mode) begin
      chr_sel = {state.chr_bank_low[4:1], address[12]};
    end else begin
      chr_sel = address[12] ? state.chr_bank_high : state.chr_bank_low;
    end
  end

  assign rom_off = {prg_sel, address[13:0]};
  assign chr_off = {1'b0, chr_sel, address[11:0]};

  always_comb begin
    result.target     = TGT_NONE;
    result.mem_offset = '0;
    if (!func[1]) begin
      if (address < RAM_BASE) begin
        result.target = TGT_NONE;
      end else if (address < REG_BASE) begin
        if (!state.prg_ram_off) begin
          result.target     = TGT_RAM;
          result.mem_offset = {5'd0, address[12:0]};
        end
      end else if (!wr) begin
        result.target     = TGT_ROM;
        result.mem_offset = rom_off;
      end
    end else if (address < PPU_LIMIT) begin
      result.target     = TGT_CHR;
      result.mem_offset = chr_off;
    end
    result.mem_write = (result.target != TGT_NONE) && wr;
    result.mem_data  = wr ? write_data : 8'd0;
  end

endmodule

`default_nettype wire

FILE: sv/serial_loaded_bank_mapper.sv
// Top level of the serial loaded bank mapper: input register, translation,
// mapper registers and result register. Depends on slbm_pkg, slbm_loader, slbm_xlate.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                         Direction
// --------  ----------------------------------------------  ---------
// in        in_valid/in_ready, func, address, write_data,   sink
//           cpu_cycle
// out       out_valid/out_ready, target, mem_offset,        source
//           mem_write, mem_data, mirroring
// cfg       cfg_valid/cfg_ready, cfg_data (prg_rom_banks)   sink
//
// One word per cycle sustained while out_ready stays high. A word accepted at one edge
// sits in the input register, is translated and updates the mapper registers as it
// moves to the result register at the next free edge, where out_valid rises.
// Synchronous reset empties both registers and loads the mapper reset state.
// A stall on out holds the result register; the input register keeps taking a
// word until it too is full, so in_ready drops only when both are occupied.
module serial_loaded_bank_mapper (
  input  wire         clk,
  input  wire         rst,
  // input words
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  func,
  input  wire  [15:0] address,
  input  wire  [7:0]  write_data,
  input  wire  [31:0] cpu_cycle,
  // result words
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  target,
  output logic [17:0] mem_offset,
  output logic        mem_write,
  output logic [7:0]  mem_data,
  output logic [1:0]  mirroring,
  // configuration
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [4:0]  cfg_data
);
  import slbm_pkg::*;

  // input register
  logic        in_full;
  logic [1:0]  func_q;
  logic [15:0] address_q;
  logic [7:0]  write_data_q;
  logic [31:0] cpu_cycle_q;

  logic [4:0]   prg_rom_banks;
  logic         move;
  logic         out_free;
  slbm_state_t  state;
  slbm_result_t result;
  logic [1:0]   mirror_next;

  assign out_free  = !out_valid || out_ready;
  assign move      = in_full && out_free;
  assign in_ready  = !in_full || out_free;
  assign cfg_ready = 1'b1;

  // hold the word until the result register has room
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q       <= func;
      address_q    <= address;
      write_data_q <= write_data;
      cpu_cycle_q  <= cpu_cycle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_banks <= PRG_BANKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      prg_rom_banks <= cfg_data;
    end
  end

  // mapper registers advance only when a word leaves the input register
  slbm_loader u_loader (
    .clk         (clk),
    .rst         (rst),
    .step        (move),
    .func        (func_q),
    .address     (address_q),
    .write_data  (write_data_q),
    .cpu_cycle   (cpu_cycle_q),
    .state       (state),
    .mirror_next (mirror_next)
  );

  // translation sees the state before this word's own register write
  slbm_xlate u_xlate (
    .func          (func_q),
    .address       (address_q),
    .write_data    (write_data_q),
    .state         (state),
    .prg_rom_banks (prg_rom_banks),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      target     <= result.target;
      mem_offset <= result.mem_offset;
      mem_write  <= result.mem_write;
      mem_data   <= result.mem_data;
      mirroring  <= mirror_next;
    end
  end

  a_move_fills: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("translated word dropped on its way to the result register");

  a_write_has_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_write |-> target != TGT_NONE)
    else $error("write strobe without a target memory");

  a_none_zero_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_NONE |-> mem_offset == 18'd0 && !mem_write)
    else $error("offset driven for an unmapped access");

  a_chr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_CHR |-> !mem_offset[17])
    else $error("CHR offset beyond 128 KiB");

endmodule

`default_nettype wire
